// File: hdl/mkd_pkg.sv
package mkd_pkg;

   // Field widths.
   localparam int UnitWidth  = 10;
   localparam int CountWidth = 14;
   localparam int KindWidth  = 3;
   localparam int CharWidth  = 7;

   // Thresholds after reset (unit of 25 ticks).
   localparam logic [UnitWidth-1:0]  UNIT_RESET = 10'd25;
   localparam logic [CountWidth-1:0] COUNT_MAX  = 14'h3FFF;

   // Longest letter in symbols.
   localparam logic [2:0] MAX_SYMBOLS = 3'd5;

   // Event kinds.
   localparam logic [KindWidth-1:0] KIND_DOT    = 3'd0;
   localparam logic [KindWidth-1:0] KIND_DASH   = 3'd1;
   localparam logic [KindWidth-1:0] KIND_LETTER = 3'd2;
   localparam logic [KindWidth-1:0] KIND_SPACE  = 3'd3;
   localparam logic [KindWidth-1:0] KIND_END    = 3'd4;

   // Characters that are emitted.
   localparam logic [CharWidth-1:0] CHAR_NONE    = 7'h00;
   localparam logic [CharWidth-1:0] CHAR_DOT     = 7'h2E;
   localparam logic [CharWidth-1:0] CHAR_DASH    = 7'h2D;
   localparam logic [CharWidth-1:0] CHAR_SPACE   = 7'h20;
   localparam logic [CharWidth-1:0] CHAR_UNKNOWN = 7'h3F;

   // Decoder state carried from one sample to the next.
   typedef struct packed {
      logic                  key_stable;
      logic                  last_sample;
      logic [CountWidth-1:0] tick_count;
      logic                  counting;
      logic [1:0]            symbol_marks;   // bit 0 dot, bit 1 dash
      logic [3:0]            gap_marks;      // symbol gap, letter, word pending, ended
      logic [7:0]            letter_code;    // count in [2:0], symbols above, 1 = dash
      logic                  letter_overflow;
      logic                  indicator;
   } state_type;

   // One result word.
   typedef struct packed {
      logic                 event_valid;
      logic [KindWidth-1:0] event_kind;
      logic [CharWidth-1:0] character;
      logic                 led_on;
   } result_type;

   // Gap thresholds in ticks, derived from the unit length.
   typedef struct packed {
      logic [11:0]           u3;
      logic [12:0]           u7;
      logic [CountWidth-1:0] u10;
   } limits_type;

   // Letter code to lower case ASCII; unknown codes give a question mark.
   function automatic logic [CharWidth-1:0] decode_letter(input logic [7:0] code);
      logic [CharWidth-1:0] ch;
      unique case (code)
         8'h12:   ch = 7'h61;
         8'h0C:   ch = 7'h62;
         8'h2C:   ch = 7'h63;
         8'h0B:   ch = 7'h64;
         8'h01:   ch = 7'h65;
         8'h24:   ch = 7'h66;
         8'h1B:   ch = 7'h67;
         8'h04:   ch = 7'h68;
         8'h02:   ch = 7'h69;
         8'h74:   ch = 7'h6A;
         8'h2B:   ch = 7'h6B;
         8'h14:   ch = 7'h6C;
         8'h1A:   ch = 7'h6D;
         8'h0A:   ch = 7'h6E;
         8'h3B:   ch = 7'h6F;
         8'h34:   ch = 7'h70;
         8'h5C:   ch = 7'h71;
         8'h13:   ch = 7'h72;
         8'h03:   ch = 7'h73;
         8'h09:   ch = 7'h74;
         8'h23:   ch = 7'h75;
         8'h44:   ch = 7'h76;
         8'h33:   ch = 7'h77;
         8'h4C:   ch = 7'h78;
         8'h6C:   ch = 7'h79;
         8'h1C:   ch = 7'h7A;
         default: ch = CHAR_UNKNOWN;
      endcase
      return ch;
   endfunction

endpackage

// File: hdl/morse_key_decoder.sv
// Morse key decoder.
// The req_ channel takes one raw key sample per word (req_key_pressed). Every
// accepted sample gives exactly one rsp_ word: rsp_event_valid marks a dot,
// dash, letter, word space or end of message (rsp_event_kind, rsp_character),
// and rsp_led_on always shows the indicator level after that sample.
// csr_write loads csr_unit_ticks, the number of samples in one Morse unit;
// write it only while no samples are in flight.
// The sample is held in an input register; then the decoder state is
// updated and the result is registered once the result register can load.
// While rsp_stall is low, throughput is one sample per cycle, set by the
// single pass from input register through step logic to result register.
// When rsp_stall is high the result register holds its word, the input
// register takes one more sample if empty, and then req_stall rises until
// the result is taken. Reset empties both registers, clears the decoder state
// and sets the unit to 25 samples.
module morse_key_decoder
   import mkd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_key_pressed,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_event_valid,
   output logic [KindWidth-1:0] rsp_event_kind,
   output logic [CharWidth-1:0] rsp_character,
   output logic                 rsp_led_on,
   input  logic                 csr_write,
   input  logic [UnitWidth-1:0] csr_unit_ticks
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic       in_key_ff;
   logic       out_valid_ff;
   logic       out_load;
   logic       step;
   logic       req_take;
   limits_type limits_ff;
   limits_type limits_in;
   state_type  state_ff;
   state_type  state_in;
   result_type result_ff;
   result_type result_in;

   // The result register can load when empty or when its word leaves.
   assign out_load  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_load;
   assign req_stall = in_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take ? 1'b1 : (step ? 1'b0 : in_valid_ff);

   // Thresholds of three, seven and ten units.
   always_comb begin
      limits_in.u3  = {1'b0, csr_unit_ticks, 1'b0} + 12'(csr_unit_ticks);
      limits_in.u7  = {csr_unit_ticks, 3'b000} - 13'(csr_unit_ticks);
      limits_in.u10 = 14'({csr_unit_ticks, 3'b000}) + 14'({csr_unit_ticks, 1'b0});
   end

   mkd_step u_step (
      .sample (in_key_ff),
      .limits (limits_ff),
      .cur    (state_ff),
      .nxt    (state_in),
      .res    (result_in)
   );

   // Control registers and decoder state.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         state_ff      <= '0;
         limits_ff.u3  <= 12'(3 * UNIT_RESET);
         limits_ff.u7  <= 13'(7 * UNIT_RESET);
         limits_ff.u10 <= 14'(10 * UNIT_RESET);
      end else begin
         in_valid_ff <= in_valid_in;
         if (out_load) begin
            out_valid_ff <= in_valid_ff;
         end
         if (step) begin
            state_ff <= state_in;
         end
         if (csr_write) begin
            limits_ff <= limits_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_key_ff <= req_key_pressed;
      end
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_event_valid = result_ff.event_valid;
   assign rsp_event_kind  = result_ff.event_kind;
   assign rsp_character   = result_ff.character;
   assign rsp_led_on      = result_ff.led_on;

endmodule

// File: hdl/mkd_step.sv
module mkd_step
   import mkd_pkg::*;
(
   input  logic       sample,
   input  limits_type limits,
   input  state_type  cur,
   output state_type  nxt,
   output result_type res
);

   logic       stable;
   logic [2:0] size;
   logic [7:0] dash_bit;

   // Symbol count and the bit position of the next symbol.
   assign size     = cur.letter_code[2:0];
   assign dash_bit = 8'b0000_1000 << size;

   always_comb begin
      nxt = cur;
      res = '0;

      // A new level is taken only when two samples in a row agree.
      stable          = (sample == cur.last_sample) ? sample : cur.key_stable;
      nxt.key_stable  = stable;
      nxt.last_sample = sample;

      if (stable && !cur.key_stable) begin
         // Press: a pending word gap is reported as a space.
         nxt.tick_count = '0;
         nxt.counting   = 1'b1;
         nxt.indicator  = 1'b0;
         if (cur.gap_marks[2]) begin
            res.event_valid = 1'b1;
            res.event_kind  = KIND_SPACE;
            res.character   = CHAR_SPACE;
         end
         nxt.gap_marks = '0;
      end else if (!stable && cur.key_stable) begin
         // Release: append the symbol to the letter and echo it.
         nxt.tick_count = '0;
         nxt.counting   = 1'b1;
         nxt.indicator  = 1'b0;
         if (cur.symbol_marks[0] || cur.symbol_marks[1]) begin
            res.event_valid = 1'b1;
            if (size >= MAX_SYMBOLS) begin
               nxt.letter_overflow = 1'b1;
            end else if (cur.symbol_marks[0]) begin
               nxt.letter_code = cur.letter_code + 8'd1;
            end else begin
               nxt.letter_code = (cur.letter_code | dash_bit) + 8'd1;
            end
            if (cur.symbol_marks[0]) begin
               res.event_kind = KIND_DOT;
               res.character  = CHAR_DOT;
            end else begin
               res.event_kind = KIND_DASH;
               res.character  = CHAR_DASH;
            end
         end
         nxt.symbol_marks = '0;
      end else if (stable) begin
         // Held: a dot first, then a dash once three units have passed.
         if (cur.tick_count < CountWidth'(limits.u3) && !cur.symbol_marks[0]) begin
            nxt.symbol_marks[0] = 1'b1;
         end else if (cur.tick_count >= CountWidth'(limits.u3) && !cur.symbol_marks[1]) begin
            nxt.symbol_marks = 2'b10;
            nxt.counting     = 1'b0;
            nxt.indicator    = 1'b1;
         end
      end else begin
         // Released: the gap length picks symbol, letter, word or end.
         if (cur.tick_count < CountWidth'(limits.u3) && !cur.gap_marks[0]) begin
            nxt.gap_marks[0] = 1'b1;
         end else if (cur.tick_count >= CountWidth'(limits.u3) &&
                      cur.tick_count < CountWidth'(limits.u7) && !cur.gap_marks[1]) begin
            nxt.gap_marks[0]    = 1'b0;
            nxt.gap_marks[1]    = 1'b1;
            nxt.indicator       = 1'b1;
            res.event_valid     = 1'b1;
            res.event_kind      = KIND_LETTER;
            res.character       = cur.letter_overflow ? CHAR_UNKNOWN
                                                      : decode_letter(cur.letter_code);
            nxt.letter_code     = '0;
            nxt.letter_overflow = 1'b0;
         end else if (cur.tick_count >= CountWidth'(limits.u7) &&
                      cur.tick_count < limits.u10 && !cur.gap_marks[2]) begin
            nxt.gap_marks[2] = 1'b1;
            nxt.indicator    = 1'b0;
         end else if (cur.tick_count >= limits.u10 && !cur.gap_marks[3]) begin
            nxt.gap_marks[2] = 1'b0;
            nxt.gap_marks[3] = 1'b1;
            nxt.counting     = 1'b0;
            res.event_valid  = 1'b1;
            res.event_kind   = KIND_END;
            res.character    = CHAR_NONE;
         end
      end

      // The tick counter saturates.
      if (nxt.counting && nxt.tick_count != COUNT_MAX) begin
         nxt.tick_count = nxt.tick_count + CountWidth'(1);
      end

      res.led_on = nxt.indicator;
   end

endmodule

// File: hdl/mkd_checker.sv
module mkd_checker
   import mkd_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_event_valid,
   input logic [KindWidth-1:0] rsp_event_kind,
   input logic [CharWidth-1:0] rsp_character,
   input logic                 rsp_led_on
);

   // A stalled result word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result word dropped while stalled");

   // Nothing comes out in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present right after reset");

   // A word without an event carries a zero kind and no character.
   a_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_event_valid |-> rsp_event_kind == KIND_DOT &&
                                        rsp_character == CHAR_NONE)
      else $error("payload on a word without event");

   // Symbols and spaces turn the indicator off, letters turn it on.
   a_led_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_valid |->
         ((rsp_event_kind == KIND_LETTER) == rsp_led_on) ||
         rsp_event_kind == KIND_END)
      else $error("indicator level does not match the event");

   // Dash echoes carry the dash character.
   a_symbol_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_valid && rsp_event_kind == KIND_DASH |->
         rsp_character == CHAR_DASH)
      else $error("dash event with wrong character");

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (.*);

// File: verif/tb_morse_key_decoder.sv
`timescale 1ns / 100ps

module tb_morse_key_decoder;
   import mkd_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 7;
   localparam int LATENCY       = 2;
   localparam int MAX_WAIT      = 19;
   localparam int HOLD_CYCLES   = 150;
   localparam int PHASE_SAMPLES = 50;
   localparam int RANDOM_PHASES = 3;

   // Bit positions of the press marks and the gap marks.
   localparam int MARK_DOT   = 0;
   localparam int MARK_DASH  = 1;
   localparam int GAP_SYMBOL = 0;
   localparam int GAP_LETTER = 1;
   localparam int GAP_WORD   = 2;
   localparam int GAP_ENDED  = 3;

   // Letter codes for a to z, letter a in the lowest byte.
   localparam logic [26*8-1:0] LETTER_CODES = {
      8'h1C, 8'h6C, 8'h4C, 8'h33, 8'h44, 8'h23, 8'h09, 8'h03, 8'h13, 8'h5C, 8'h34, 8'h3B, 8'h0A,
      8'h1A, 8'h14, 8'h2B, 8'h74, 8'h02, 8'h04, 8'h1B, 8'h24, 8'h01, 8'h0B, 8'h2C, 8'h0C, 8'h12
   };
   localparam logic [CharWidth-1:0] LOWER_A = 7'h61;

   logic                 clock           = 1'b0;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_stall;
   logic                 req_key_pressed = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall       = 1'b0;
   logic                 rsp_event_valid;
   logic [KindWidth-1:0] rsp_event_kind;
   logic [CharWidth-1:0] rsp_character;
   logic                 rsp_led_on;
   logic                 csr_write       = 1'b0;
   logic [UnitWidth-1:0] csr_unit_ticks  = UNIT_RESET;

   // Key samples waiting to be sent and decoder words still to arrive.
   logic       key_samples [$];
   result_type expected_events [$];

   int error_count    = 0;
   int send_wait      = 0;
   int recv_wait      = 0;
   bit sender_idles   = 1'b1;
   bit receiver_idles = 1'b1;
   bit add_glitches   = 1'b0;
   bit hold_request   = 1'b0;
   bit hold_off       = 1'b0;

   // Decoder state as predicted by the testbench.
   logic [UnitWidth-1:0]  dec_unit     = UNIT_RESET;
   logic                  dec_stable   = 1'b0;
   logic                  dec_last     = 1'b0;
   logic [CountWidth-1:0] dec_ticks    = '0;
   logic                  dec_running  = 1'b0;
   logic [1:0]            dec_symbol   = '0;
   logic [3:0]            dec_gap      = '0;
   logic [7:0]            dec_letter   = '0;
   logic                  dec_overflow = 1'b0;
   logic                  dec_led      = 1'b0;

   morse_key_decoder uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_key_pressed (req_key_pressed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_event_valid (rsp_event_valid),
      .rsp_event_kind  (rsp_event_kind),
      .rsp_character   (rsp_character),
      .rsp_led_on      (rsp_led_on),
      .csr_write       (csr_write),
      .csr_unit_ticks  (csr_unit_ticks)
   );

   always #(HALF_PERIOD) clock = ~clock;

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Mostly back to back, sometimes a random pause bounded by MAX_WAIT.
   function automatic int draw_wait(input bit enabled);
      if (!enabled || $urandom_range(0, 3) != 0)
         return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // A symbol joins the letter; past five symbols only the overflow flag is set.
   task automatic append_symbol(input bit dash);
      if (dec_letter[2:0] >= MAX_SYMBOLS) begin
         dec_overflow = 1'b1;
      end else begin
         if (dash)
            dec_letter[3 + dec_letter[2:0]] = 1'b1;
         dec_letter = dec_letter + 8'd1;
      end
   endtask

   // Advances the predicted decoder by one key sample and queues the word it yields.
   task automatic decode_key_sample(input logic sample);
      result_type res;
      logic       prev;
      int         u3, u7, u10, c, i;
      res  = '0;
      prev = dec_stable;
      u3   = 3 * int'(dec_unit);
      u7   = 7 * int'(dec_unit);
      u10  = 10 * int'(dec_unit);
      c    = int'(dec_ticks);

      // Debounce: a level counts once two samples in a row agree.
      if (sample == dec_last)
         dec_stable = sample;
      dec_last = sample;

      if (dec_stable && !prev) begin
         // Press: a pending word gap turns into a space.
         dec_ticks   = '0;
         dec_running = 1'b1;
         dec_led     = 1'b0;
         if (dec_gap[GAP_WORD]) begin
            res.event_valid = 1'b1;
            res.event_kind  = KIND_SPACE;
            res.character   = CHAR_SPACE;
         end
         dec_gap = '0;
      end else if (!dec_stable && prev) begin
         // Release: the symbol that the press made is added and echoed.
         dec_ticks   = '0;
         dec_running = 1'b1;
         dec_led     = 1'b0;
         if (dec_symbol[MARK_DOT]) begin
            append_symbol(1'b0);
            res.event_valid = 1'b1;
            res.event_kind  = KIND_DOT;
            res.character   = CHAR_DOT;
         end else if (dec_symbol[MARK_DASH]) begin
            append_symbol(1'b1);
            res.event_valid = 1'b1;
            res.event_kind  = KIND_DASH;
            res.character   = CHAR_DASH;
         end
         dec_symbol = '0;
      end else if (dec_stable) begin
         // Held: a dot first, a dash once three units have passed.
         if (c < u3 && !dec_symbol[MARK_DOT]) begin
            dec_symbol[MARK_DOT] = 1'b1;
         end else if (c >= u3 && !dec_symbol[MARK_DASH]) begin
            dec_symbol  = 2'b10;
            dec_running = 1'b0;
            dec_led     = 1'b1;
         end
      end else begin
         // Released: the gap length picks symbol gap, letter, word gap or end.
         if (c < u3 && !dec_gap[GAP_SYMBOL]) begin
            dec_gap[GAP_SYMBOL] = 1'b1;
         end else if (c >= u3 && c < u7 && !dec_gap[GAP_LETTER]) begin
            dec_gap[GAP_SYMBOL] = 1'b0;
            dec_gap[GAP_LETTER] = 1'b1;
            dec_led = 1'b1;
            res.event_valid = 1'b1;
            res.event_kind  = KIND_LETTER;
            res.character   = CHAR_UNKNOWN;
            if (!dec_overflow) begin
               for (i = 0; i < 26; i++)
                  if (LETTER_CODES[i*8 +: 8] == dec_letter)
                     res.character = LOWER_A + CharWidth'(i);
            end
            dec_letter   = '0;
            dec_overflow = 1'b0;
         end else if (c >= u7 && c < u10 && !dec_gap[GAP_WORD]) begin
            dec_gap[GAP_WORD] = 1'b1;
            dec_led = 1'b0;
         end else if (c >= u10 && !dec_gap[GAP_ENDED]) begin
            dec_gap[GAP_WORD]  = 1'b0;
            dec_gap[GAP_ENDED] = 1'b1;
            dec_running = 1'b0;
            res.event_valid = 1'b1;
            res.event_kind  = KIND_END;
            res.character   = CHAR_NONE;
         end
      end

      if (dec_running && dec_ticks < COUNT_MAX)
         dec_ticks = dec_ticks + 1'b1;
      res.led_on = dec_led;
      expected_events.push_back(res);
   endtask

   // A run of one key level, with rare single-sample glitches when enabled.
   task automatic queue_level(input logic level, input int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (add_glitches && i > 0 && i < count - 1 && $urandom_range(0, 31) == 0)
            key_samples.push_back(~level);
         else
            key_samples.push_back(level);
      end
   endtask

   // Keys a letter given as dots and dashes, then releases for the given gap.
   task automatic queue_pattern(input string symbols, input int unit, input int gap);
      int k;
      for (k = 0; k < symbols.len(); k++) begin
         if (k > 0)
            queue_level(1'b0, unit + 2);
         queue_level(1'b1, (symbols[k] == "-") ? 4 * unit + 2 : unit + 2);
      end
      queue_level(1'b0, gap);
   endtask

   // Mostly well-formed letters with random timing; some too long, some run together.
   task automatic queue_random_message(input int unit);
      int letters, symbols, n, k;
      letters = $urandom_range(1, 4);
      for (n = 0; n < letters; n++) begin
         symbols = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 7) : $urandom_range(1, 5);
         for (k = 0; k < symbols; k++) begin
            if (k > 0)
               queue_level(1'b0, $urandom_range(2, 3 * unit + 1));
            if ($urandom_range(0, 1))
               queue_level(1'b1, $urandom_range(2, 3 * unit + 1));
            else
               queue_level(1'b1, $urandom_range(3 * unit + 2, 5 * unit + 3));
         end
         case ($urandom_range(0, 5))
            0: queue_level(1'b0, $urandom_range(2, 3 * unit + 1));
            1: queue_level(1'b0, $urandom_range(7 * unit + 2, 10 * unit + 1));
            default: queue_level(1'b0, $urandom_range(3 * unit + 2, 7 * unit + 1));
         endcase
      end
      if ($urandom_range(0, 2) == 0)
         queue_level(1'b0, $urandom_range(10 * unit + 2, 12 * unit + 4));
   endtask

   // Waits until every sample is sent and every word is back, plus the pipeline depth.
   task automatic wait_idle();
      while (key_samples.size() != 0 || req_valid || expected_events.size() != 0)
         @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   task automatic write_unit(input int unit);
      @(posedge clock);
      csr_write      <= 1'b1;
      csr_unit_ticks <= UnitWidth'(unit);
      dec_unit = UnitWidth'(unit);
      @(posedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Driver: sends queued key samples, one word per accepted handshake.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         if (req_valid && !req_stall) begin
            decode_key_sample(req_key_pressed);
            send_wait = draw_wait(sender_idles);
         end
         if (req_valid && req_stall) begin
            // The stalled word stays on the port.
         end else if (send_wait > 0) begin
            send_wait--;
            req_valid <= 1'b0;
         end else if (key_samples.size() > 0) begin
            req_valid       <= 1'b1;
            req_key_pressed <= key_samples.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each accepted result word against the oldest prediction.
   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               report_mismatch("result word arrived with none expected");
            end else begin
               want = expected_events.pop_front();
               if (rsp_event_valid !== want.event_valid)
                  report_mismatch($sformatf("event_valid %0d, expected %0d",
                                            rsp_event_valid, want.event_valid));
               if (rsp_event_kind !== want.event_kind)
                  report_mismatch($sformatf("event_kind %0d, expected %0d",
                                            rsp_event_kind, want.event_kind));
               if (rsp_character !== want.character)
                  report_mismatch($sformatf("character 0x%0h, expected 0x%0h",
                                            rsp_character, want.character));
               if (rsp_led_on !== want.led_on)
                  report_mismatch($sformatf("led_on %0d, expected %0d",
                                            rsp_led_on, want.led_on));
            end
            recv_wait = draw_wait(receiver_idles);
         end else if (rsp_valid && recv_wait > 0) begin
            recv_wait--;
         end
         rsp_stall <= hold_off || (recv_wait > 0);
      end
   end

   // Long receiver hold-off so the block fills up and stalls its input.
   initial begin : receiver_hold
      wait (hold_request);
      @(negedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_off = 1'b0;
   end

   initial begin : watchdog
      #(60_000_000);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin : stimulus
      int p, unit;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Unit after reset: e, word gap, then a space before t and the end of message.
      queue_pattern(".", UNIT_RESET, 8 * UNIT_RESET + 2);
      queue_pattern("-", UNIT_RESET, 10 * UNIT_RESET + 4);
      wait_idle();

      // Short unit: known letters, an unknown code and letters of six and seven symbols.
      write_unit(2);
      queue_pattern(".-", 2, 12);
      queue_pattern("...", 2, 12);
      queue_pattern("---", 2, 12);
      queue_pattern(".---", 2, 12);
      queue_pattern("--.-", 2, 12);
      queue_pattern("--..", 2, 12);
      queue_pattern("..--", 2, 12);
      queue_pattern("......", 2, 12);
      queue_pattern(".-.-.-.", 2, 18);
      queue_pattern("-", 2, 12);
      queue_pattern(".", 2, 24);
      // A press with a single-sample glitch stays one symbol, a dash.
      queue_level(1'b1, 3);
      key_samples.push_back(1'b0);
      queue_level(1'b1, 3);
      queue_level(1'b0, 24);
      wait_idle();

      // Zero unit: every threshold is passed at once.
      write_unit(0);
      queue_pattern(".-", 0, 4);
      queue_pattern("-", 0, 3);
      wait_idle();

      // Unit shrinks in the middle of a gap; the letter is then decoded under the new unit.
      write_unit(4);
      queue_level(1'b1, 18);
      queue_level(1'b0, 6);
      wait_idle();
      write_unit(1);
      queue_level(1'b0, 20);
      wait_idle();

      // Unit of 1000: a short press is a dot and a short release only a symbol gap.
      // The dot stays in the letter and joins the first random letter.
      write_unit(1000);
      queue_level(1'b1, 10);
      queue_level(1'b0, 10);
      wait_idle();

      // Random messages over several unit settings.
      add_glitches = 1'b1;
      for (p = 0; p < RANDOM_PHASES; p++) begin
         unit = (p == 0) ? 1 : $urandom_range(1, 3);
         write_unit(unit);
         sender_idles   = (p % 3 != 2);
         receiver_idles = (p != 1);
         while (key_samples.size() < PHASE_SAMPLES) begin
            if ($urandom_range(0, 7) == 0)
               queue_level(1'($urandom_range(0, 1)), $urandom_range(1, 12));
            else
               queue_random_message(unit);
         end
         if (p == 2) begin
            sender_idles = 1'b0;
            hold_request = 1'b1;
         end
         wait_idle();
      end

      repeat (LATENCY + 8) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
